/* design/tclp_pkg.sv */
// shared types, constants and helpers for the timed cue list player
// no dependencies; imported by the top level and the checker

package tclp_pkg;

    // ring queue depth and line length limit
    localparam int RING_DEPTH = 16;
    localparam int LINE_BYTES = 32;

    localparam int QADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(RING_DEPTH + 1);
    localparam int QSUM_W  = QADDR_W + 1;
    localparam int LLEN_W  = $clog2(LINE_BYTES);

    localparam int TIME_W  = 32;
    localparam int MASK_W  = 16;
    localparam int CUE_W   = TIME_W + MASK_W;

    // event codes
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_CHAR  = 3'd2;
    localparam logic [2:0] OP_EOF   = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;

    // character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_A  = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    // line parser phases
    typedef enum logic [2:0] {
        PH_LEAD = 3'd0,
        PH_DEC  = 3'd1,
        PH_SEP  = 3'd2,
        PH_HEX  = 3'd3,
        PH_DONE = 3'd4,
        PH_DROP = 3'd5
    } phase_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_EXEC    = 5'b00010,
        ST_TICK_RD = 5'b00100,
        ST_TICK_CMP = 5'b01000,
        ST_DONE    = 5'b10000
    } state_t;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF_A)) ||
               ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    // nibble value of a hex digit, meaningful only where is_hex holds
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (is_dec(c)) begin
            v = c[3:0];
        end else begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

/* design/timed_cue_list_player_top.sv */
// timed cue list player: line parser, cue ring queue and tick sequencer
// depends on tclp_pkg and tclp_ram
//
// flow: start, stop, text and end-of-file events pass from input transfer
//   through the exec and done states to the result register; a tick walks
//   the read and compare states once per popped cue, via the cue-memory read port
// a new event is taken only after the result of the last one is loaded; s_ready
//   is high only while the sequencer idles
// reset: aresetn clears flags, queue pointers, parser and output valid; cue memory
//   holds no reset and is read only where it was written

module timed_cue_list_player_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_opcode,
    input  logic [7:0]                  s_char_code,
    input  logic [31:0]                 s_now_ms,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [15:0]                 m_light_mask,
    output logic                        m_playing,
    output logic [tclp_pkg::QCNT_W-1:0] m_pending_cues,
    output logic                        m_end_seen
);

    import tclp_pkg::*;

    state_t              state_reg, state_next;
    logic [2:0]          op_reg;
    logic [7:0]          char_reg;
    logic [TIME_W-1:0]   now_reg;

    logic                active_reg, active_next;
    logic                eof_reg, eof_next;
    logic [QADDR_W-1:0]  head_reg, head_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;
    logic [TIME_W-1:0]   start_reg, start_next;
    logic [TIME_W-1:0]   pos_reg, pos_next;
    logic [LLEN_W-1:0]   len_reg, len_next;
    phase_t              phase_reg, phase_next;
    logic [TIME_W-1:0]   tacc_reg, tacc_next;
    logic [MASK_W-1:0]   macc_reg, macc_next;

    logic                m_valid_reg, m_valid_next;
    logic [MASK_W-1:0]   out_mask_reg;
    logic                out_play_reg;
    logic [QCNT_W-1:0]   out_count_reg;
    logic                out_eof_reg;
    logic                out_load;

    logic                wr_en;
    logic [QADDR_W-1:0]  tail;
    logic [QSUM_W-1:0]   tail_sum;
    logic [CUE_W-1:0]    rd_data;
    logic [TIME_W-1:0]   rd_time;
    logic [MASK_W-1:0]   rd_mask;
    logic [TIME_W-1:0]   dec_next;
    logic                line_ok;

    assign s_ready = (state_reg == ST_IDLE);

    // cue storage, read address follows the queue head
    tclp_ram #(
        .WIDTH (CUE_W),
        .DEPTH (RING_DEPTH)
    ) u_cue_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail),
        .wr_data ({tacc_reg, macc_reg}),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    assign rd_time = rd_data[CUE_W-1:MASK_W];
    assign rd_mask = rd_data[MASK_W-1:0];

    // tail slot of the ring
    always_comb begin
        tail_sum = QSUM_W'(head_reg) + QSUM_W'(count_reg);
        if (tail_sum >= QSUM_W'(RING_DEPTH)) begin
            tail_sum = tail_sum - QSUM_W'(RING_DEPTH);
        end
        tail = tail_sum[QADDR_W-1:0];
    end

    // decimal accumulate, times ten as two shifts
    assign dec_next = (tacc_reg << 3) + (tacc_reg << 1) + TIME_W'(char_reg[3:0]);

    assign line_ok = ((phase_reg == PH_HEX) || (phase_reg == PH_DONE)) &&
                     (count_reg < QCNT_W'(RING_DEPTH));

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next  = state_reg;
        active_next = active_reg;
        eof_next    = eof_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        mask_next   = mask_reg;
        start_next  = start_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        phase_next  = phase_reg;
        tacc_next   = tacc_reg;
        macc_next   = macc_reg;
        wr_en       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                unique case (op_reg)
                    OP_START: begin
                        active_next = 1'b1;
                        eof_next    = 1'b0;
                        head_next   = '0;
                        count_next  = '0;
                        mask_next   = '0;
                        start_next  = now_reg;
                        len_next    = '0;
                        phase_next  = PH_LEAD;
                        tacc_next   = '0;
                        macc_next   = '0;
                    end
                    OP_STOP: begin
                        active_next = 1'b0;
                        mask_next   = '0;
                    end
                    OP_CHAR, OP_EOF: begin
                        if (active_reg) begin
                            if ((op_reg == OP_EOF) || (char_reg == CH_LF) ||
                                (char_reg == CH_CR)) begin
                                // line end: push a good cue, reset the parser
                                if (line_ok) begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                                len_next   = '0;
                                phase_next = PH_LEAD;
                                tacc_next  = '0;
                                macc_next  = '0;
                                if (op_reg == OP_EOF) begin
                                    eof_next = 1'b1;
                                end
                            end else if (len_reg < LLEN_W'(LINE_BYTES - 1)) begin
                                len_next = len_reg + 1'b1;
                                unique case (phase_reg)
                                    PH_LEAD: begin
                                        if (is_dec(char_reg)) begin
                                            tacc_next  = TIME_W'(char_reg[3:0]);
                                            phase_next = PH_DEC;
                                        end else if (char_reg != CH_SPACE) begin
                                            phase_next = PH_DROP;
                                        end
                                    end
                                    PH_DEC: begin
                                        if (is_dec(char_reg)) begin
                                            tacc_next = dec_next;
                                        end else if (char_reg == CH_SPACE) begin
                                            phase_next = PH_SEP;
                                        end else begin
                                            phase_next = PH_DROP;
                                        end
                                    end
                                    PH_SEP: begin
                                        if (is_hex(char_reg)) begin
                                            macc_next  = MASK_W'(hex_val(char_reg));
                                            phase_next = PH_HEX;
                                        end else if (char_reg != CH_SPACE) begin
                                            phase_next = PH_DROP;
                                        end
                                    end
                                    PH_HEX: begin
                                        if (is_hex(char_reg)) begin
                                            macc_next = {macc_reg[MASK_W-5:0],
                                                         hex_val(char_reg)};
                                        end else begin
                                            phase_next = PH_DONE;
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                    end
                    OP_TICK: begin
                        if (active_reg) begin
                            pos_next   = now_reg - start_reg;
                            state_next = ST_TICK_RD;
                        end else begin
                            mask_next = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_TICK_RD: begin
                // ram data for the current head shows up next cycle
                state_next = ST_TICK_CMP;
            end
            ST_TICK_CMP: begin
                if ((count_reg != '0) && (rd_time <= pos_reg)) begin
                    mask_next  = rd_mask;
                    count_next = count_reg - 1'b1;
                    if (head_reg == QADDR_W'(RING_DEPTH - 1)) begin
                        head_next = '0;
                    end else begin
                        head_next = head_reg + 1'b1;
                    end
                    state_next = ST_TICK_RD;
                end else begin
                    if (eof_reg && (count_reg == '0)) begin
                        mask_next   = '0;
                        active_next = 1'b0;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= 1'b0;
            eof_reg     <= 1'b0;
            head_reg    <= '0;
            count_reg   <= '0;
            mask_reg    <= '0;
            start_reg   <= '0;
            len_reg     <= '0;
            phase_reg   <= PH_LEAD;
            tacc_reg    <= '0;
            macc_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            eof_reg     <= eof_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            mask_reg    <= mask_next;
            start_reg   <= start_next;
            len_reg     <= len_next;
            phase_reg   <= phase_next;
            tacc_reg    <= tacc_next;
            macc_reg    <= macc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // captured event and result payload
    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        if (s_valid && s_ready) begin
            op_reg   <= s_opcode;
            char_reg <= s_char_code;
            now_reg  <= s_now_ms;
        end
        if (out_load) begin
            out_mask_reg  <= mask_reg;
            out_play_reg  <= active_reg;
            out_count_reg <= count_reg;
            out_eof_reg   <= eof_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_light_mask   = out_mask_reg;
    assign m_playing      = out_play_reg;
    assign m_pending_cues = out_count_reg;
    assign m_end_seen     = out_eof_reg;

endmodule

/* design/tclp_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies

module tclp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* design/tclp_checker.sv */
// port-level checks for the timed cue list player, with its bind
// depends on tclp_pkg and timed_cue_list_player_top

module tclp_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [15:0]                 m_light_mask,
    input logic                        m_playing,
    input logic [tclp_pkg::QCNT_W-1:0] m_pending_cues,
    input logic                        m_end_seen
);

    import tclp_pkg::*;

    // stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_light_mask) &&
        $stable(m_playing) && $stable(m_pending_cues) && $stable(m_end_seen))
        else $error("result changed while stalled");

    // lights are dark whenever the show is not playing
    a_dark_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_playing |-> m_light_mask == '0)
        else $error("mask set while not playing");

    // queue fill never passes the ring depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pending_cues <= QCNT_W'(RING_DEPTH))
        else $error("pending cue count out of range");

    // one event at a time: no transfer right after a transfer
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

endmodule

bind timed_cue_list_player_top tclp_checker u_tclp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_light_mask   (m_light_mask),
    .m_playing      (m_playing),
    .m_pending_cues (m_pending_cues),
    .m_end_seen     (m_end_seen)
);
